// ===== rtl/core/rgbaenc_pkg.sv =====
// Package for the RGBA pixel encoder: sizes, status codes and the item types
// passed between the front classifier, the queue and the back encoder.
// No dependencies.
`default_nettype none
package rgbaenc_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int SLOT_W          = $clog2(PALETTE_ENTRIES);
    localparam int COUNT_W         = $clog2(PALETTE_ENTRIES + 1);
    localparam int COLOR_W         = 9;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INEXACT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BLUE    = 2'd3;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_DIRECT  = 1'b1;

    // classified pixel
    typedef struct packed {
        logic       inexact;
        logic       first;
        logic [2:0] red;
        logic [2:0] green;
        logic [2:0] blue;
    } item_t;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] entry_blue;
        logic [2:0] entry_green;
        logic [2:0] entry_red;
        logic [3:0] entry_slot;
        logic       new_entry;
        logic       byte_valid;
        logic [7:0] byte_out;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/rgbaenc_front.sv =====
// Front classifier: composites a pixel over white, reduces each channel to its
// top 3-bit level and flags the pixel inexact unless all three levels are exact. Depends on rgbaenc_pkg.
`default_nettype none
module rgbaenc_front
(
    input  wire logic [7:0]          red,
    input  wire logic [7:0]          green,
    input  wire logic [7:0]          blue,
    input  wire logic [7:0]          alpha,
    input  wire logic                first_pixel,
    output rgbaenc_pkg::item_t       item
);

    // blend over white, divide by 255 with rounding; x < 2^16 so the
    // reciprocal form (x + (x >> 8) + 1) >> 8 is exact
    function automatic logic [7:0] blend_white(input logic [7:0] c, input logic [7:0] a);
        logic [16:0] x;
        logic [16:0] q;
        begin
            x = ({9'd0, c} * {9'd0, a})
                + ({9'd0, 8'd255} * ({9'd0, 8'd255} - {9'd0, a}))
                + 17'd127;
            q = (x + (x >> 8) + 17'd1) >> 8;
            blend_white = q[7:0];
        end
    endfunction

    function automatic logic exact(input logic [7:0] v);
        logic [2:0] l;
        begin
            l = v[7:5];
            exact = ({l, l, l[2:1]} == v);
        end
    endfunction

    logic [7:0] r_c;
    logic [7:0] g_c;
    logic [7:0] b_c;

    always_comb
    begin
        r_c = blend_white(red, alpha);
        g_c = blend_white(green, alpha);
        b_c = blend_white(blue, alpha);
        item.inexact = !(exact(r_c) && exact(g_c) && exact(b_c));
        item.first   = first_pixel;
        item.red     = r_c[7:5];
        item.green   = g_c[7:5];
        item.blue    = b_c[7:5];
    end

endmodule
`default_nettype wire

// ===== rtl/core/rgbaenc_queue.sv =====
// Short queue of classified items between front and back.
// Depends on rgbaenc_pkg.
`default_nettype none
module rgbaenc_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire rgbaenc_pkg::item_t  push_item,
    output logic                     full,
    input  wire logic                pop,
    output rgbaenc_pkg::item_t       pop_item,
    output logic                     not_empty
);

    rgbaenc_pkg::item_t                      slot_reg [rgbaenc_pkg::QUEUE_DEPTH];
    logic [rgbaenc_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [rgbaenc_pkg::QPTR_W-1:0]          wr_ptr_next;
    logic [rgbaenc_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [rgbaenc_pkg::QPTR_W-1:0]          rd_ptr_next;
    logic [rgbaenc_pkg::QCNT_W-1:0]          cnt_reg;
    logic [rgbaenc_pkg::QCNT_W-1:0]          cnt_next;
    logic                                    do_push;
    logic                                    do_pop;

    assign full      = (cnt_reg == rgbaenc_pkg::QCNT_W'(rgbaenc_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 1'b1 : 1'b0);
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rgbaenc_back.sv =====
// Back encoder: palette lookup and append, nibble pairing, direct GGGRRRBB
// coding and the result register. Depends on rgbaenc_pkg.
`default_nettype none
module rgbaenc_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                mode,
    input  wire logic                item_valid,
    input  wire rgbaenc_pkg::item_t  item,
    output logic                     item_pop,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output rgbaenc_pkg::result_t     result
);

    localparam int N  = rgbaenc_pkg::PALETTE_ENTRIES;
    localparam int SW = rgbaenc_pkg::SLOT_W;
    localparam int CW = rgbaenc_pkg::COUNT_W;

    logic [rgbaenc_pkg::COLOR_W-1:0] palette_reg [N];
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [3:0]                      pending_reg;
    logic [3:0]                      pending_next;
    logic                            phase_reg;
    logic                            phase_next;
    logic                            res_valid_reg;
    logic                            res_valid_next;
    rgbaenc_pkg::result_t            result_reg;
    rgbaenc_pkg::result_t            result_next;

    logic                            take;
    logic [rgbaenc_pkg::COLOR_W-1:0] color;
    logic [CW-1:0]                   count_eff;
    logic                            phase_eff;
    logic [N-1:0]                    hit;
    logic [SW-1:0]                   hit_idx;
    logic [SW-1:0]                   idx;
    logic                            pal_we;
    logic [SW-1:0]                   pal_waddr;
    logic [1:0]                      bb;

    assign take      = item_valid && (!res_valid_reg || res_ready);
    assign item_pop  = take;
    assign res_valid = res_valid_reg;
    assign result    = result_reg;
    assign color     = {item.red, item.green, item.blue};
    assign count_eff = item.first ? '0 : count_reg;
    assign phase_eff = item.first ? 1'b0 : phase_reg;

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            hit[i] = (CW'(i) < count_eff) && (palette_reg[i] == color);
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        pending_next   = pending_reg;
        phase_next     = phase_reg;
        result_next    = '0;
        res_valid_next = res_valid_reg && !res_ready;
        pal_we         = 1'b0;
        pal_waddr      = count_eff[SW-1:0];
        idx            = hit_idx;
        bb             = (item.blue == 3'd7) ? 2'd3 : item.blue[2:1];

        if (take)
        begin
            res_valid_next = 1'b1;
            if (item.inexact)
            begin
                result_next.status = rgbaenc_pkg::ST_INEXACT;
            end
            else if (mode == rgbaenc_pkg::MODE_DIRECT)
            begin
                if (item.blue inside {3'd1, 3'd3, 3'd5, 3'd6})
                begin
                    result_next.status = rgbaenc_pkg::ST_BLUE;
                end
                else
                begin
                    if (item.first)
                    begin
                        count_next   = '0;
                        phase_next   = 1'b0;
                        pending_next = '0;
                    end
                    result_next.byte_out   = {item.green, item.red, bb};
                    result_next.byte_valid = 1'b1;
                    result_next.status     = rgbaenc_pkg::ST_OK;
                end
            end
            else if (!(|hit) && (count_eff == CW'(N)))
            begin
                result_next.status = rgbaenc_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_eff;
                if (!(|hit))
                begin
                    idx                     = count_eff[SW-1:0];
                    pal_we                  = 1'b1;
                    count_next              = count_eff + 1'b1;
                    result_next.new_entry   = 1'b1;
                    result_next.entry_slot  = 4'(count_eff[SW-1:0]);
                    result_next.entry_red   = item.red;
                    result_next.entry_green = item.green;
                    result_next.entry_blue  = item.blue;
                end
                if (!phase_eff)
                begin
                    pending_next = 4'(idx);
                    phase_next   = 1'b1;
                end
                else
                begin
                    result_next.byte_out   = {pending_reg, 4'(idx)};
                    result_next.byte_valid = 1'b1;
                    phase_next             = 1'b0;
                end
                result_next.status = rgbaenc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pending_reg   <= '0;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
        if (pal_we)
        begin
            palette_reg[pal_waddr] <= color;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rgba_to_indexed_or_direct_pixel_encoder.sv =====
// Path: an accepted pixel is written into a queue slot, then taken by the back
// encoder into the result register, which holds the result while it is stalled.
// Throughput: one pixel per cycle while the output is not stalled, set by the back
// encoder's palette compare and append; a two-item queue decouples front and back.
// Reset: queue, result valid, palette count, nibble phase and mode clear
// at once; palette entries are not cleared (only slots below the count are read).
// Top level: stream ports, mode register, front/queue/back. Uses rgbaenc_pkg.
`default_nettype none
module rgba_to_indexed_or_direct_pixel_encoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,      // mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    input  wire logic        s_axis_tuser,   // first_pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // byte_out, byte_valid, new_entry,
                                             // entry_slot, entry_red, entry_green,
                                             // entry_blue, status, zero pad
);

    logic                 mode_reg;
    rgbaenc_pkg::item_t   front_item;
    rgbaenc_pkg::item_t   q_item;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 q_pop;
    rgbaenc_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rgbaenc_pkg::MODE_PALETTE;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    rgbaenc_front u_front
    (
        .red         (s_axis_tdata[7:0]),
        .green       (s_axis_tdata[15:8]),
        .blue        (s_axis_tdata[23:16]),
        .alpha       (s_axis_tdata[31:24]),
        .first_pixel (s_axis_tuser),
        .item        (front_item)
    );

    assign s_axis_tready = !q_full;

    rgbaenc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    rgbaenc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .item_valid (q_not_empty),
        .item       (q_item),
        .item_pop   (q_pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .result     (res)
    );

    assign m_axis_tdata = {7'd0, res};

endmodule
`default_nettype wire

// ===== rtl/core/rgbaenc_checker.sv =====
// Port-level checker for the RGBA pixel encoder, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none
module rgbaenc_assertions
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_we,
    input wire logic        cfg_wdata,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[24:23] != 2'd0) |-> (m_axis_tdata[22:0] == 23'd0))
        else $error("error item carries data");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[8] |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("byte_out nonzero without byte_valid");

    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> (m_axis_tdata[22:10] == 13'd0))
        else $error("entry fields nonzero without new_entry");

endmodule

bind rgba_to_indexed_or_direct_pixel_encoder rgbaenc_assertions u_rgbaenc_assertions (.*);
`default_nettype wire
